FILE: rtl/core/skm_pkg.sv
// ============================================================================
// skm_pkg
// Shared types and constants of the sequential k-means clusterer.
// ============================================================================
package skm_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int MAX_DIMS     = 8;
    localparam int MAX_CLUSTERS = 8;
    localparam int COORD_BITS   = 16;

    localparam int PT_BITS   = $clog2(MAX_POINTS);
    localparam int DIM_BITS  = $clog2(MAX_DIMS);
    localparam int CL_BITS   = $clog2(MAX_CLUSTERS);
    localparam int CNT_BITS  = PT_BITS + 1;
    localparam int LAB_BITS  = CL_BITS + 1;
    localparam int CFG_BITS  = 11;

    // Multiplier operands, product, and the dividend of a mean update.
    localparam int OPND_BITS = COORD_BITS + 2;
    localparam int PROD_BITS = 2 * OPND_BITS;
    localparam int NUM_BITS  = COORD_BITS + CNT_BITS + 2;
    localparam int QCNT_BITS = $clog2(NUM_BITS + 1);
    localparam int SQ_BITS   = 2 * COORD_BITS + 1;
    localparam int SUM_BITS  = SQ_BITS + DIM_BITS;

    localparam logic [LAB_BITS-1:0] UNASSIGNED = LAB_BITS'(MAX_CLUSTERS);

    typedef enum logic [1:0] {
        ACT_LOAD       = 2'd0,
        ACT_RUN        = 2'd1,
        ACT_READ_LABEL = 2'd2,
        ACT_READ_MEAN  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_DIMS       = 2'd0,
        CFG_CLUSTERS   = 2'd1,
        CFG_POINTS     = 2'd2,
        CFG_MAX_PASSES = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]                   action;
        logic [PT_BITS-1:0]           point_index;
        logic [DIM_BITS-1:0]          dim_index;
        logic [CL_BITS-1:0]           cluster_index;
        logic signed [COORD_BITS-1:0] coord;
    } t_in_item;

    typedef struct packed {
        logic [LAB_BITS-1:0]          label;
        logic signed [COORD_BITS-1:0] mean_value;
        logic [CNT_BITS-1:0]          member_count;
        logic [7:0]                   passes_done;
        logic                         converged;
    } t_out_item;

    typedef struct packed {
        logic signed [OPND_BITS-1:0] mul_a;
        logic signed [OPND_BITS-1:0] mul_b;
        logic                        div_go;
        logic signed [NUM_BITS-1:0]  div_num;
        logic [CNT_BITS-1:0]         div_den;
    } t_arith_req;

    typedef struct packed {
        logic signed [PROD_BITS-1:0] prod;
        logic                        div_done;
        logic signed [NUM_BITS-1:0]  quot;
    } t_arith_rsp;

endpackage

FILE: rtl/core/skm_chan_if.sv
// ============================================================================
// skm_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ============================================================================
interface skm_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/skm_arith.sv
// ============================================================================
// skm_arith
// Shared arithmetic unit: a registered signed multiplier and a restoring
// divider that produces one quotient bit a cycle, truncating toward zero.
// ============================================================================
module skm_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  skm_pkg::t_arith_req i_req,
    output skm_pkg::t_arith_rsp o_rsp
);
    localparam int NB = skm_pkg::NUM_BITS;
    localparam int DB = skm_pkg::CNT_BITS;

    logic signed [skm_pkg::PROD_BITS-1:0] r_prod;
    logic [NB-1:0]                        r_quo;
    logic [DB-1:0]                        r_rem;
    logic [DB-1:0]                        r_den;
    logic                                 r_neg;
    logic                                 r_busy;
    logic                                 r_done;
    logic [skm_pkg::QCNT_BITS-1:0]        r_cnt;

    logic [DB:0]   shifted;
    logic [DB:0]   trial;
    logic          fits;
    logic [NB-1:0] mag;

    assign shifted = {r_rem, r_quo[NB-1]};
    assign trial   = shifted - {1'b0, r_den};
    assign fits    = (shifted >= {1'b0, r_den});
    assign mag     = i_req.div_num[NB-1] ? NB'(-i_req.div_num) : NB'(i_req.div_num);

    always_ff @(posedge i_clk) begin
        r_prod <= i_req.mul_a * i_req.mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.div_go) begin
                r_busy <= 1'b1;
                r_cnt  <= skm_pkg::QCNT_BITS'(NB);
                r_quo  <= mag;
                r_rem  <= '0;
                r_den  <= i_req.div_den;
                r_neg  <= i_req.div_num[NB-1];
            end else if (r_busy) begin
                r_rem <= fits ? trial[DB-1:0] : shifted[DB-1:0];
                r_quo <= {r_quo[NB-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == skm_pkg::QCNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.prod     = r_prod;
    assign o_rsp.div_done = r_done;
    assign o_rsp.quot     = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule

FILE: rtl/core/sequential_kmeans_clusterer.sv
// ============================================================================
// sequential_kmeans_clusterer
// Point store with online k-means: loads coordinates, runs assignment passes
// through one shared multiply/divide unit, and answers label and mean reads.
// ============================================================================
//  channel   direction  handshake      payload
//  i_in      sink       valid/ready    action, point_index, dim_index,
//                                      cluster_index, coord
//  o_out     source     valid/ready    label, mean_value, member_count,
//                                      passes_done, converged
//  i_cfg_*   write      write enable   register index, data
//
// A load gives its item in the cycle after acceptance; a read first registers
// the fetched label or mean in ST_RD. A run starts with a sweep over every
// label address that clears labels and means, then per pass and point runs a
// distance search over each dimension and cluster, plus a mean update per
// dimension through the serial divider when the point moves. After reset the
// same sweep runs before the first item is taken. One item is in work at a
// time; a new item is not taken while a result still waits on o_out.
module sequential_kmeans_clusterer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    skm_chan_if.sink                      i_in,
    skm_chan_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [skm_pkg::CFG_BITS-1:0]  i_cfg_data
);
    localparam int PB = skm_pkg::PT_BITS;
    localparam int EB = skm_pkg::DIM_BITS;
    localparam int KB = skm_pkg::CL_BITS;
    localparam int CB = skm_pkg::COORD_BITS;
    localparam int NB = skm_pkg::CNT_BITS;
    localparam int LB = skm_pkg::LAB_BITS;
    localparam int SB = skm_pkg::SUM_BITS;
    localparam int QB = skm_pkg::NUM_BITS;
    localparam int OB = skm_pkg::OPND_BITS;
    localparam logic signed [QB-1:0] Q_MAX = QB'((1 <<< (CB - 1)) - 1);
    localparam logic signed [QB-1:0] Q_MIN = -QB'(1 <<< (CB - 1));

    typedef enum logic [20:0] {
        ST_CLR      = 21'd1 << 0,
        ST_IDLE     = 21'd1 << 1,
        ST_RD       = 21'd1 << 2,
        ST_PASS     = 21'd1 << 3,
        ST_PT       = 21'd1 << 4,
        ST_SEED_RD  = 21'd1 << 5,
        ST_SEED_WR  = 21'd1 << 6,
        ST_DIST_RD  = 21'd1 << 7,
        ST_DIST_MUL = 21'd1 << 8,
        ST_DIST_ACC = 21'd1 << 9,
        ST_DECIDE   = 21'd1 << 10,
        ST_UPD_RD   = 21'd1 << 11,
        ST_UPD_MUL  = 21'd1 << 12,
        ST_UPD_DIV  = 21'd1 << 13,
        ST_UPD_WAIT = 21'd1 << 14,
        ST_UPD_END  = 21'd1 << 15,
        ST_UPD_CHK  = 21'd1 << 16,
        ST_FINISH   = 21'd1 << 17,
        ST_NEXT     = 21'd1 << 18,
        ST_PASS_END = 21'd1 << 19,
        ST_DONE     = 21'd1 << 20
    } t_state;

    t_state r_state;

    // Configuration registers and their saturated forms.
    logic [3:0]    r_dims;
    logic [3:0]    r_clus;
    logic [NB-1:0] r_ptot;
    logic [7:0]    r_maxp;
    logic [3:0]    dims_m1;
    logic [3:0]    clus_m1;
    logic [NB-1:0] ptot_m1;
    logic [EB-1:0] nd_m1;
    logic [KB-1:0] nk_m1;
    logic [PB-1:0] np_m1;
    logic [7:0]    mp_m1;

    // Memories.
    logic signed [CB-1:0] r_pmem [skm_pkg::MAX_POINTS * skm_pkg::MAX_DIMS];
    logic [LB-1:0]        r_lmem [skm_pkg::MAX_POINTS];
    logic signed [CB-1:0] r_mmem [skm_pkg::MAX_CLUSTERS * skm_pkg::MAX_DIMS];
    logic signed [CB-1:0] r_pdata;
    logic [LB-1:0]        r_ldata;
    logic signed [CB-1:0] r_mdata;
    logic [NB-1:0]        r_cnt [skm_pkg::MAX_CLUSTERS];

    // Sequencer registers.
    logic [PB-1:0] r_clr_idx;
    logic          r_clr_run;
    logic [PB-1:0] r_pt;
    logic [KB-1:0] r_k;
    logic [EB-1:0] r_e;
    logic [7:0]    r_pidx;
    logic [7:0]    r_pass_done;
    logic          r_conv;
    logic          r_moved;
    logic [SB-1:0] r_sum;
    logic [SB-1:0] r_bestd;
    logic [KB-1:0] r_bestk;
    logic [NB-1:0] r_un;
    logic          r_sub;
    logic [1:0]    r_act;
    logic [KB-1:0] r_ci;
    logic          r_out_valid;
    skm_pkg::t_out_item r_out;

    skm_pkg::t_in_item   in_item;
    skm_pkg::t_arith_req a_req;
    skm_pkg::t_arith_rsp a_rsp;
    logic                in_acc;

    logic [PB+EB-1:0] p_raddr;
    logic [PB-1:0]    l_raddr;
    logic [KB+EB-1:0] m_raddr;
    logic             m_we;
    logic [KB+EB-1:0] m_waddr;
    logic signed [CB-1:0] m_wdata;
    logic             l_we;
    logic [PB-1:0]    l_waddr;
    logic [LB-1:0]    l_wdata;
    logic [KB-1:0]    cnt_sel;
    logic [NB-1:0]    cnt_rd;
    logic signed [CB:0] diff;
    logic [SB-1:0]    sum_new;
    logic signed [QB-1:0] x_ext;
    logic signed [QB-1:0] q;
    logic signed [CB-1:0] q_sat;

    assign in_item    = i_in.data;
    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE) && !r_out_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign dims_m1 = r_dims - 4'd1;
    assign clus_m1 = r_clus - 4'd1;
    assign ptot_m1 = r_ptot - 1'b1;
    always_comb begin
        nd_m1 = (r_dims == '0) ? '0 : (r_dims > 4'(skm_pkg::MAX_DIMS)) ? '1 : dims_m1[EB-1:0];
        nk_m1 = (r_clus == '0) ? '0
              : (r_clus > 4'(skm_pkg::MAX_CLUSTERS)) ? '1 : clus_m1[KB-1:0];
        np_m1 = (r_ptot == '0) ? '0
              : (r_ptot > NB'(skm_pkg::MAX_POINTS)) ? '1 : ptot_m1[PB-1:0];
        mp_m1 = (r_maxp == '0) ? '0 : r_maxp - 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= 4'd2;
            r_clus <= 4'd2;
            r_ptot <= NB'(16);
            r_maxp <= 8'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                skm_pkg::CFG_DIMS:       r_dims <= i_cfg_data[3:0];
                skm_pkg::CFG_CLUSTERS:   r_clus <= i_cfg_data[3:0];
                skm_pkg::CFG_POINTS:     r_ptot <= i_cfg_data[NB-1:0];
                skm_pkg::CFG_MAX_PASSES: r_maxp <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Label and mean addresses: item while idle, sequencer otherwise; point address: sequencer.
    always_comb begin
        if (r_state == ST_IDLE) begin
            l_raddr = in_item.point_index;
            m_raddr = {in_item.cluster_index, in_item.dim_index};
        end else begin
            l_raddr = r_pt;
            m_raddr = {r_k, r_e};
        end
        p_raddr = {r_pt, r_e};
    end

    // Mean and label write ports.
    always_comb begin
        m_we    = 1'b0;
        m_waddr = {r_k, r_e};
        m_wdata = q_sat;
        l_we    = 1'b0;
        l_waddr = r_pt;
        l_wdata = {1'b0, r_bestk};
        case (r_state)
            ST_CLR: begin
                m_we    = (r_clr_idx < PB'(skm_pkg::MAX_CLUSTERS * skm_pkg::MAX_DIMS));
                m_waddr = r_clr_idx[KB+EB-1:0];
                m_wdata = '0;
                l_we    = 1'b1;
                l_waddr = r_clr_idx;
                l_wdata = skm_pkg::UNASSIGNED;
            end
            ST_SEED_WR: begin
                m_we    = 1'b1;
                m_waddr = {r_pt[KB-1:0], r_e};
                m_wdata = r_pdata;
                l_we    = (r_e == nd_m1);
                l_wdata = {1'b0, r_pt[KB-1:0]};
            end
            ST_UPD_WAIT: m_we = a_rsp.div_done;
            ST_FINISH:   l_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_item.action == skm_pkg::ACT_LOAD) begin
            r_pmem[{in_item.point_index, in_item.dim_index}] <= in_item.coord;
        end
        r_pdata <= r_pmem[p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            r_lmem[l_waddr] <= l_wdata;
        end
        r_ldata <= r_lmem[l_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mmem[m_waddr] <= m_wdata;
        end
        r_mdata <= r_mmem[m_raddr];
    end

    // Member count selection: gaining cluster, losing cluster, or read address.
    always_comb begin
        case (r_state)
            ST_DECIDE:            cnt_sel = r_bestk;
            ST_UPD_END, ST_FINISH: cnt_sel = r_k;
            default:              cnt_sel = r_ci;
        endcase
    end
    assign cnt_rd = r_cnt[cnt_sel];

    // Arithmetic requests.
    assign diff  = (CB+1)'(r_mdata) - (CB+1)'(r_pdata);
    assign x_ext = QB'(r_pdata);
    always_comb begin
        a_req.div_go  = (r_state == ST_UPD_DIV);
        a_req.div_den = r_sub ? r_un - 1'b1 : r_un + 1'b1;
        a_req.div_num = r_sub ? a_rsp.prod[QB-1:0] - x_ext : a_rsp.prod[QB-1:0] + x_ext;
        if (r_state == ST_UPD_MUL) begin
            a_req.mul_a = OB'(r_mdata);
            a_req.mul_b = $signed({{(OB-NB){1'b0}}, r_un});
        end else begin
            a_req.mul_a = OB'(diff);
            a_req.mul_b = OB'(diff);
        end
    end

    skm_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (a_req),
        .o_rsp   (a_rsp)
    );

    assign q       = a_rsp.quot;
    assign q_sat   = (q > Q_MAX) ? Q_MAX[CB-1:0] : (q < Q_MIN) ? Q_MIN[CB-1:0] : q[CB-1:0];
    assign sum_new = r_sum + SB'(a_rsp.prod[skm_pkg::SQ_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr_idx   <= '0;
            r_clr_run   <= 1'b0;
            r_out_valid <= 1'b0;
            r_pass_done <= '0;
            r_conv      <= 1'b0;
            for (int c = 0; c < skm_pkg::MAX_CLUSTERS; c++) begin
                r_cnt[c] <= '0;
            end
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == '1) begin
                        r_state <= r_clr_run ? ST_PASS : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_act <= in_item.action;
                        r_ci  <= in_item.cluster_index;
                        unique case (in_item.action)
                            skm_pkg::ACT_LOAD: begin
                                r_out       <= '{label: '0, mean_value: '0, member_count: '0,
                                                 passes_done: r_pass_done, converged: r_conv};
                                r_out_valid <= 1'b1;
                            end
                            skm_pkg::ACT_RUN: begin
                                r_clr_idx   <= '0;
                                r_clr_run   <= 1'b1;
                                r_pidx      <= '0;
                                r_pass_done <= '0;
                                r_conv      <= 1'b0;
                                for (int c = 0; c < skm_pkg::MAX_CLUSTERS; c++) begin
                                    r_cnt[c] <= '0;
                                end
                                r_state <= ST_CLR;
                            end
                            default: r_state <= ST_RD;
                        endcase
                    end
                end
                ST_RD: begin
                    r_out.label        <= (r_act == skm_pkg::ACT_READ_LABEL) ? r_ldata : '0;
                    r_out.mean_value   <= (r_act == skm_pkg::ACT_READ_MEAN) ? r_mdata : '0;
                    r_out.member_count <= (r_act == skm_pkg::ACT_READ_MEAN) ? cnt_rd : '0;
                    r_out.passes_done  <= r_pass_done;
                    r_out.converged    <= r_conv;
                    r_out_valid        <= 1'b1;
                    r_state            <= ST_IDLE;
                end
                ST_PASS: begin
                    r_pass_done <= r_pidx + 8'd1;
                    r_moved     <= 1'b0;
                    r_pt        <= '0;
                    r_state     <= ST_PT;
                end
                ST_PT: begin
                    r_e   <= '0;
                    r_k   <= '0;
                    r_sum <= '0;
                    if (r_pidx == '0 && r_pt <= PB'(nk_m1)) begin
                        r_state <= ST_SEED_RD;
                    end else begin
                        r_state <= ST_DIST_RD;
                    end
                end
                ST_SEED_RD: r_state <= ST_SEED_WR;
                ST_SEED_WR: begin
                    if (r_e == nd_m1) begin
                        r_cnt[r_pt[KB-1:0]] <= NB'(1);
                        r_moved <= 1'b1;
                        r_state <= ST_NEXT;
                    end else begin
                        r_e     <= r_e + 1'b1;
                        r_state <= ST_SEED_RD;
                    end
                end
                ST_DIST_RD:  r_state <= ST_DIST_MUL;
                ST_DIST_MUL: r_state <= ST_DIST_ACC;
                ST_DIST_ACC: begin
                    if (r_e == nd_m1) begin
                        // Strict compare keeps the lower cluster on a tie.
                        if (r_k == '0 || sum_new < r_bestd) begin
                            r_bestd <= sum_new;
                            r_bestk <= r_k;
                        end
                        r_e   <= '0;
                        r_sum <= '0;
                        if (r_k == nk_m1) begin
                            r_state <= ST_DECIDE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_DIST_RD;
                        end
                    end else begin
                        r_sum   <= sum_new;
                        r_e     <= r_e + 1'b1;
                        r_state <= ST_DIST_RD;
                    end
                end
                ST_DECIDE: begin
                    if ({1'b0, r_bestk} == r_ldata) begin
                        r_state <= ST_NEXT;
                    end else begin
                        r_moved <= 1'b1;
                        r_k     <= r_bestk;
                        r_un    <= cnt_rd;
                        r_sub   <= 1'b0;
                        r_e     <= '0;
                        r_state <= ST_UPD_RD;
                    end
                end
                ST_UPD_RD:  r_state <= ST_UPD_MUL;
                ST_UPD_MUL: r_state <= ST_UPD_DIV;
                ST_UPD_DIV: r_state <= ST_UPD_WAIT;
                ST_UPD_WAIT: begin
                    if (a_rsp.div_done) begin
                        if (r_e == nd_m1) begin
                            r_state <= ST_UPD_END;
                        end else begin
                            r_e     <= r_e + 1'b1;
                            r_state <= ST_UPD_RD;
                        end
                    end
                end
                ST_UPD_END: begin
                    if (!r_sub) begin
                        r_cnt[r_k] <= r_un + 1'b1;
                        if (!r_ldata[LB-1]) begin
                            r_k     <= r_ldata[KB-1:0];
                            r_sub   <= 1'b1;
                            r_state <= ST_UPD_CHK;
                        end else begin
                            r_state <= ST_FINISH;
                        end
                    end else begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_UPD_CHK: begin
                    // Count of the losing cluster; a cluster going empty keeps its mean.
                    r_un <= r_cnt[r_k];
                    r_e  <= '0;
                    if (r_cnt[r_k] > NB'(1)) begin
                        r_state <= ST_UPD_RD;
                    end else begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!r_ldata[LB-1] && cnt_rd != '0) begin
                        r_cnt[r_k] <= cnt_rd - 1'b1;
                    end
                    r_state <= ST_NEXT;
                end
                ST_NEXT: begin
                    if (r_pt == np_m1) begin
                        r_state <= ST_PASS_END;
                    end else begin
                        r_pt    <= r_pt + 1'b1;
                        r_state <= ST_PT;
                    end
                end
                ST_PASS_END: begin
                    if (!r_moved) begin
                        r_conv  <= 1'b1;
                        r_state <= ST_DONE;
                    end else if (r_pidx == mp_m1) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_pidx  <= r_pidx + 8'd1;
                        r_state <= ST_PASS;
                    end
                end
                ST_DONE: begin
                    r_out       <= '{label: '0, mean_value: '0, member_count: '0,
                                     passes_done: r_pass_done, converged: r_conv};
                    r_out_valid <= 1'b1;
                    r_clr_run   <= 1'b0;
                    r_state     <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the sequential k-means clusterer. Coordinates are
// loaded, runs are started and labels and means are read back; every result
// item is checked against a cycle-free k-means predictor or fixed directed values.
// ============================================================================
module tb;

    localparam longint CYCLE_LIMIT = 100_000_000;

    typedef struct {
        skm_pkg::t_action   act;
        int                 pt;
        int                 dim;
        int                 cl;
        int                 val;
        bit                 typed;
        skm_pkg::t_out_item res;
    } t_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [1:0]                   i_cfg_idx;
    logic [skm_pkg::CFG_BITS-1:0] i_cfg_data;

    skm_chan_if #(.t_payload(skm_pkg::t_in_item))  in_ch ();
    skm_chan_if #(.t_payload(skm_pkg::t_out_item)) out_ch ();

    sequential_kmeans_clusterer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the block's state.
    int        coords [skm_pkg::MAX_POINTS][skm_pkg::MAX_DIMS];
    bit        coord_set [skm_pkg::MAX_POINTS][skm_pkg::MAX_DIMS];
    int        labels [skm_pkg::MAX_POINTS];
    int        means [skm_pkg::MAX_CLUSTERS][skm_pkg::MAX_DIMS];
    int        counts [skm_pkg::MAX_CLUSTERS];
    int        passes;
    int        conv;
    bit        means_valid;
    int        reg_dims, reg_clusters, reg_points, reg_passes;

    skm_pkg::t_out_item pending_results[$];
    longint    cycles = 0;
    int        errors, checked, n_items, n_runs;
    bit        quiet;
    bit        hold_req;
    int        hold_left, stall_left;
    int        centres [4][skm_pkg::MAX_DIMS];

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("sequential_kmeans_clusterer test failed");
            $finish;
        end
    end

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int sat_coord(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic longint unsigned sq_dist(int c, int p, int nd);
        longint unsigned sum;
        longint diff;
        sum = 0;
        for (int e = 0; e < nd; e++) begin
            diff = longint'(means[c][e]) - longint'(coords[p][e]);
            sum += longint'(diff * diff);
        end
        return sum;
    endfunction

    // Online k-means over the loaded points with the current settings.
    function automatic void cluster_points();
        int nd, nk, np, mp, old, best;
        longint unsigned best_d, d;
        longint n;
        bit moved;
        nd = clampi(reg_dims, 1, skm_pkg::MAX_DIMS);
        nk = clampi(reg_clusters, 1, skm_pkg::MAX_CLUSTERS);
        np = clampi(reg_points, 1, skm_pkg::MAX_POINTS);
        mp = clampi(reg_passes, 1, 255);
        foreach (labels[i]) labels[i] = skm_pkg::MAX_CLUSTERS;
        foreach (means[c, e]) means[c][e] = 0;
        foreach (counts[c]) counts[c] = 0;
        passes = 0;
        conv = 0;
        means_valid = 1;
        for (int pass = 0; pass < mp; pass++) begin
            moved = 0;
            passes = pass + 1;
            for (int i = 0; i < np; i++) begin
                old = labels[i];
                if (pass == 0 && i < nk) begin
                    for (int e = 0; e < nd; e++) means[i][e] = coords[i][e];
                    counts[i] = 1;
                    labels[i] = i;
                    moved = 1;
                    continue;
                end
                best = 0;
                best_d = 0;
                for (int c = 0; c < nk; c++) begin
                    d = sq_dist(c, i, nd);
                    if (c == 0 || d < best_d) begin
                        best_d = d;
                        best = c;
                    end
                end
                if (best == old) continue;
                moved = 1;
                n = counts[best];
                for (int e = 0; e < nd; e++)
                    means[best][e] = sat_coord((means[best][e] * n + coords[i][e]) / (n + 1));
                counts[best]++;
                if (old < skm_pkg::MAX_CLUSTERS) begin
                    n = counts[old];
                    // A cluster left empty keeps its last mean.
                    if (n > 1)
                        for (int e = 0; e < nd; e++)
                            means[old][e] =
                                sat_coord((means[old][e] * n - coords[i][e]) / (n - 1));
                    if (counts[old] > 0) counts[old]--;
                end
                labels[i] = best;
            end
            if (!moved) begin
                conv = 1;
                break;
            end
        end
    endfunction

    function automatic skm_pkg::t_out_item apply_item(skm_pkg::t_in_item it);
        skm_pkg::t_out_item r;
        r = '0;
        case (skm_pkg::t_action'(it.action))
            skm_pkg::ACT_LOAD: begin
                coords[it.point_index][it.dim_index] = it.coord;
                coord_set[it.point_index][it.dim_index] = 1;
            end
            skm_pkg::ACT_RUN: begin
                cluster_points();
                n_runs++;
            end
            skm_pkg::ACT_READ_LABEL:
                r.label = skm_pkg::LAB_BITS'(labels[it.point_index]);
            skm_pkg::ACT_READ_MEAN: begin
                r.member_count = skm_pkg::CNT_BITS'(counts[it.cluster_index]);
                r.mean_value   = skm_pkg::COORD_BITS'(means[it.cluster_index][it.dim_index]);
            end
        endcase
        r.passes_done = 8'(passes);
        r.converged   = conv[0];
        return r;
    endfunction

    // Offers one item; the result is predicted at the edge where it is taken.
    task automatic send(skm_pkg::t_in_item it, bit typed, skm_pkg::t_out_item typed_res);
        int gap;
        skm_pkg::t_out_item r;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        r = apply_item(it);
        pending_results.push_back(typed ? typed_res : r);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() > 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic cfg_write(skm_pkg::t_cfg_idx idx, int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= skm_pkg::CFG_BITS'(value);
        @(negedge i_clk);
    endtask

    task automatic configure(int d, int k, int p, int m);
        drain();
        cfg_write(skm_pkg::CFG_DIMS, d);
        cfg_write(skm_pkg::CFG_CLUSTERS, k);
        cfg_write(skm_pkg::CFG_POINTS, p);
        cfg_write(skm_pkg::CFG_MAX_PASSES, m);
        i_cfg_we <= 1'b0;
        reg_dims     = d & 'hF;
        reg_clusters = k & 'hF;
        reg_points   = p & 'h7FF;
        reg_passes   = m & 'hFF;
        @(negedge i_clk);
    endtask

    function automatic int pick_coord(int dim);
        if ($urandom_range(0, 3) == 0) return int'($signed(16'($urandom)));
        return sat_coord(centres[$urandom_range(0, 3)][dim] + $urandom_range(0, 1536) - 768);
    endfunction

    function automatic skm_pkg::t_in_item load_item(int p, int d);
        skm_pkg::t_in_item it;
        it = '0;
        it.action      = skm_pkg::ACT_LOAD;
        it.point_index = skm_pkg::PT_BITS'(p);
        it.dim_index   = skm_pkg::DIM_BITS'(d);
        it.coord       = skm_pkg::COORD_BITS'(pick_coord(d));
        return it;
    endfunction

    // Makes sure every coordinate a run will read has been written.
    task automatic fill_points();
        int nd, np;
        nd = clampi(reg_dims, 1, skm_pkg::MAX_DIMS);
        np = clampi(reg_points, 1, skm_pkg::MAX_POINTS);
        for (int p = 0; p < np; p++)
            for (int d = 0; d < nd; d++)
                if (!coord_set[p][d]) send(load_item(p, d), 0, '0);
    endtask

    task automatic random_items(int count);
        skm_pkg::t_in_item it;
        int np, sel;
        np = clampi(reg_points, 1, skm_pkg::MAX_POINTS);
        for (int n = 0; n < count; n++) begin
            it = '0;
            it.point_index   = skm_pkg::PT_BITS'($urandom_range(0, 3) == 0
                                                 ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, np - 1));
            it.dim_index     = skm_pkg::DIM_BITS'($urandom_range(0, 7));
            it.cluster_index = skm_pkg::CL_BITS'($urandom_range(0, 7));
            it.coord         = skm_pkg::COORD_BITS'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 3) begin
                it.action = skm_pkg::ACT_RUN;
            end else if (sel < 40) begin
                it = load_item(it.point_index, it.dim_index);
            end else if (sel < 68 || !means_valid) begin
                it.action = skm_pkg::ACT_READ_LABEL;
            end else begin
                it.action = skm_pkg::ACT_READ_MEAN;
            end
            send(it, 0, '0);
        end
    endtask

    // Result side: random back-pressure and one long hold-off on request.
    initial begin
        out_ch.ready = 1'b0;
        hold_left = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (quiet) begin
                out_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 7);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result item %p", $time, out_ch.data);
                errors++;
            end else begin
                if (out_ch.data !== pending_results[0]) begin
                    $display("%0t mismatch: expected %p, actual %p", $time,
                             pending_results[0], out_ch.data);
                    errors++;
                end
                void'(pending_results.pop_front());
                checked++;
            end
        end
    end

    initial begin
        t_row               rows [$];
        skm_pkg::t_out_item blank, unassigned_res;
        skm_pkg::t_in_item  it;

        errors = 0;
        checked = 0;
        n_items = 0;
        n_runs = 0;
        quiet = 0;
        hold_req = 0;
        means_valid = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        foreach (labels[i]) labels[i] = skm_pkg::MAX_CLUSTERS;
        foreach (means[c, e]) means[c][e] = 0;
        foreach (counts[c]) counts[c] = 0;
        passes = 0;
        conv = 0;
        reg_dims = 2;
        reg_clusters = 2;
        reg_points = 16;
        reg_passes = 64;
        foreach (centres[k, d]) centres[k][d] = int'($signed(16'($urandom))) / 2;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        blank = '0;
        unassigned_res = '0;
        unassigned_res.label = skm_pkg::UNASSIGNED;

        // Directed: reset state, coordinate extremes, fewer points than clusters.
        rows = '{
            '{skm_pkg::ACT_READ_LABEL, 0,    0, 0, 0,      1, unassigned_res},
            '{skm_pkg::ACT_READ_LABEL, 1023, 0, 0, 0,      1, unassigned_res},
            '{skm_pkg::ACT_LOAD,       0,    0, 0, -32768, 1, blank},
            '{skm_pkg::ACT_LOAD,       0,    1, 0, -32768, 1, blank},
            '{skm_pkg::ACT_LOAD,       1,    0, 0, 32767,  1, blank},
            '{skm_pkg::ACT_LOAD,       1,    1, 0, 32767,  1, blank},
            '{skm_pkg::ACT_LOAD,       2,    0, 0, 32767,  1, blank},
            '{skm_pkg::ACT_LOAD,       2,    1, 0, -32768, 1, blank},
            '{skm_pkg::ACT_LOAD,       1023, 7, 0, 'h5A5A, 1, blank},
            '{skm_pkg::ACT_RUN,        0,    0, 0, 0,      0, blank},
            '{skm_pkg::ACT_READ_LABEL, 0,    0, 0, 0,      0, blank},
            '{skm_pkg::ACT_READ_LABEL, 2,    0, 0, 0,      0, blank},
            '{skm_pkg::ACT_READ_LABEL, 3,    0, 0, 0,      0, blank},
            '{skm_pkg::ACT_READ_MEAN,  0,    0, 0, 0,      0, blank},
            '{skm_pkg::ACT_READ_MEAN,  0,    1, 1, 0,      0, blank},
            '{skm_pkg::ACT_READ_MEAN,  0,    1, 2, 0,      0, blank},
            '{skm_pkg::ACT_READ_MEAN,  0,    0, 3, 0,      0, blank},
            '{skm_pkg::ACT_READ_MEAN,  0,    7, 7, 0,      0, blank},
            '{skm_pkg::ACT_LOAD,       2,    0, 0, -32768, 0, blank},
            '{skm_pkg::ACT_RUN,        0,    0, 0, 0,      0, blank},
            '{skm_pkg::ACT_READ_LABEL, 1,    0, 0, 0,      0, blank},
            '{skm_pkg::ACT_READ_MEAN,  0,    0, 2, 0,      0, blank}
        };
        configure(2, 4, 3, 8);
        foreach (rows[r]) begin
            it = '0;
            it.action        = rows[r].act;
            it.point_index   = skm_pkg::PT_BITS'(rows[r].pt);
            it.dim_index     = skm_pkg::DIM_BITS'(rows[r].dim);
            it.cluster_index = skm_pkg::CL_BITS'(rows[r].cl);
            it.coord         = skm_pkg::COORD_BITS'(rows[r].val);
            send(it, rows[r].typed, rows[r].res);
        end

        // Upper extremes of dimensions, clusters and passes, held back by a long result stall at the start.
        configure(8, 8, 10, 255);
        hold_req = 1;
        fill_points();
        random_items(150);

        // Zero settings saturate to one dimension, one cluster, one point, one pass.
        configure(0, 0, 0, 0);
        fill_points();
        send('{action: skm_pkg::ACT_RUN, default: '0}, 0, '0);
        random_items(40);

        configure(1, 1, 1, 1);
        fill_points();
        random_items(120);

        configure(9, 12, 7, 3);
        fill_points();
        random_items(150);

        configure(3, 5, 20, 6);
        fill_points();
        random_items(150);

        // Last stretch with both sides running flat out.
        configure(2, 3, 10, 10);
        quiet = 1;
        fill_points();
        random_items(150);

        drain();
        repeat (50) @(negedge i_clk);
        $display("Covered %0d items with %0d clustering runs; %0d results checked.",
                 n_items, n_runs, checked);
        $display("Settings spanned zero, saturating and maximal register values.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("sequential_kmeans_clusterer test passed");
        end else begin
            $display("sequential_kmeans_clusterer test failed");
        end
        $finish;
    end
endmodule

FILE: sequential_kmeans_clusterer.f
rtl/core/skm_pkg.sv
rtl/core/skm_chan_if.sv
rtl/core/skm_arith.sv
rtl/core/sequential_kmeans_clusterer.sv
verif/tb.sv
